@@ rtl/cfpr_pkg.sv @@
package cfpr_pkg;

   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_ABORT   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_READ    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      PH_LEN     = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_CRC_LO  = 2'd2,
      PH_CRC_HI  = 2'd3
   } rx_phase_type;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_XOUT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // reflected CRC-16-CCITT, one byte, LSB first
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/crc_framed_packet_receiver.sv @@
// Channel | Direction | Ports
// --------+-----------+-------------------------------------------------------------
// req     | in        | req_valid, req_stall, req_opcode, req_data_byte,
//         |           | req_buffer_sel, req_byte_index
// rsp     | out       | rsp_valid, rsp_stall, rsp_frame_ready, rsp_crc_bad,
//         |           | rsp_length_dropped, rsp_ready_buffer, rsp_ready_pending,
//         |           | rsp_ready_length, rsp_read_data
//
// One word accepted per cycle while req_stall is low; its response word passes through the
// payload store read and the output register.
// After reset the payload store is zeroed one byte a cycle, and req_stall stays high
// until the clearing pass is done.
// rsp_stall holds the output register; req_stall rises while the store is cleared, or
// when the read stage is full and the output register is full and stalled.
module crc_framed_packet_receiver #(
   parameter int MTU = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_data_byte,
   input  logic       req_buffer_sel,
   input  logic [4:0] req_byte_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_frame_ready,
   output logic       rsp_crc_bad,
   output logic       rsp_length_dropped,
   output logic       rsp_ready_buffer,
   output logic       rsp_ready_pending,
   output logic [7:0] rsp_ready_length,
   output logic [7:0] rsp_read_data
);

   localparam int DEPTH = 2 * MTU;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MTU);
   localparam logic [AW-1:0] BUF1_BASE = AW'(MTU);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MTU - 1);
   localparam logic [8:0]    MTU_W     = 9'(MTU);

   // receive state
   cfpr_pkg::rx_phase_type phase_ff, phase_in;
   logic [15:0]   crc_ff, crc_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    crc_low_ff, crc_low_in;
   logic          fill_ff, fill_in;
   logic          ready_idx_ff, ready_idx_in;
   logic [1:0]    buf_new_ff, buf_new_in;
   logic [7:0]    len_ff [2];
   logic [7:0]    len_in [2];

   // clearing pass
   logic          clear_ff;
   logic [AW-1:0] clear_addr_ff;

   // payload store
   logic [7:0]    mem [DEPTH];
   logic [7:0]    mem_rdata_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   // read stage
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_frame_ready_ff, s1_crc_bad_ff, s1_dropped_ff;
   logic       s1_ready_buf_ff, s1_pending_ff, s1_use_rd_ff;
   logic [7:0] s1_ready_len_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       o_frame_ready_ff, o_crc_bad_ff, o_dropped_ff;
   logic       o_ready_buf_ff, o_pending_ff;
   logic [7:0] o_ready_len_ff, o_read_data_ff;

   logic          accept;
   logic          out_free;
   logic          ev_frame_ready, ev_crc_bad, ev_dropped;
   logic [15:0]   crc_upd;
   logic [CW-1:0] count_next;
   logic          rd_in_range;
   cfpr_pkg::opcode_type op;

   assign op          = cfpr_pkg::opcode_type'(req_opcode);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = clear_ff || (s1_valid_ff && !out_free);
   assign accept      = req_valid && !req_stall;
   assign crc_upd     = cfpr_pkg::crc_add(crc_ff, req_data_byte);
   assign count_next  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign rd_in_range = {4'b0000, req_byte_index} < MTU_W;
   assign rd_addr     = req_buffer_sel ? BUF1_BASE + AW'(req_byte_index)
                                       : AW'(req_byte_index);

   always_comb begin
      phase_in       = phase_ff;
      crc_in         = crc_ff;
      count_in       = count_ff;
      crc_low_in     = crc_low_ff;
      fill_in        = fill_ff;
      ready_idx_in   = ready_idx_ff;
      buf_new_in     = buf_new_ff;
      len_in         = len_ff;
      ev_frame_ready = 1'b0;
      ev_crc_bad     = 1'b0;
      ev_dropped     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = fill_ff ? BUF1_BASE + AW'(count_ff) : AW'(count_ff);
      unique case (op)
         cfpr_pkg::OP_RX_BYTE: begin
            unique case (phase_ff)
               cfpr_pkg::PH_LEN: begin
                  if (buf_new_ff[fill_ff]) begin
                     ev_dropped = 1'b1;
                     crc_in     = cfpr_pkg::CRC_INIT;
                  end else begin
                     crc_in          = crc_upd;
                     len_in[fill_ff] = req_data_byte;
                     count_in        = '0;
                     phase_in        = cfpr_pkg::PH_PAYLOAD;
                  end
               end
               cfpr_pkg::PH_PAYLOAD: begin
                  wr_en    = 1'b1;
                  crc_in   = crc_upd;
                  count_in = count_next;
                  if (9'(count_next) == {1'b0, len_ff[fill_ff]}) begin
                     crc_in   = crc_upd ^ cfpr_pkg::CRC_XOUT;
                     phase_in = cfpr_pkg::PH_CRC_LO;
                  end
               end
               cfpr_pkg::PH_CRC_LO: begin
                  crc_low_in = req_data_byte;
                  phase_in   = cfpr_pkg::PH_CRC_HI;
               end
               cfpr_pkg::PH_CRC_HI: begin
                  if ({req_data_byte, crc_low_ff} == crc_ff) begin
                     ready_idx_in        = fill_ff;
                     buf_new_in[fill_ff] = 1'b1;
                     fill_in             = !fill_ff;
                     ev_frame_ready      = 1'b1;
                  end else begin
                     ev_crc_bad = 1'b1;
                  end
                  phase_in = cfpr_pkg::PH_LEN;
                  crc_in   = cfpr_pkg::CRC_INIT;
               end
               default: begin
                  phase_in = cfpr_pkg::PH_LEN;
               end
            endcase
         end
         cfpr_pkg::OP_ABORT: begin
            phase_in = cfpr_pkg::PH_LEN;
            crc_in   = cfpr_pkg::CRC_INIT;
         end
         cfpr_pkg::OP_RELEASE: begin
            buf_new_in[req_buffer_sel] = 1'b0;
         end
         cfpr_pkg::OP_READ: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cfpr_pkg::PH_LEN;
         crc_ff       <= cfpr_pkg::CRC_INIT;
         count_ff     <= '0;
         crc_low_ff   <= '0;
         fill_ff      <= 1'b0;
         ready_idx_ff <= 1'b1;
         buf_new_ff   <= '0;
         len_ff[0]    <= '0;
         len_ff[1]    <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         crc_low_ff   <= crc_low_in;
         fill_ff      <= fill_in;
         ready_idx_ff <= ready_idx_in;
         buf_new_ff   <= buf_new_in;
         len_ff       <= len_in;
      end
   end

   // zero the store after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clear_addr_ff] <= 8'h00;
      end else if (accept && wr_en) begin
         mem[wr_addr] <= req_data_byte;
      end
   end

   // read data holds while the read stage waits
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_frame_ready_ff <= ev_frame_ready;
         s1_crc_bad_ff     <= ev_crc_bad;
         s1_dropped_ff     <= ev_dropped;
         s1_ready_buf_ff   <= ready_idx_in;
         s1_pending_ff     <= buf_new_in[ready_idx_in];
         s1_ready_len_ff   <= len_in[ready_idx_in];
         s1_use_rd_ff      <= (op == cfpr_pkg::OP_READ) && rd_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         o_frame_ready_ff <= s1_frame_ready_ff;
         o_crc_bad_ff     <= s1_crc_bad_ff;
         o_dropped_ff     <= s1_dropped_ff;
         o_ready_buf_ff   <= s1_ready_buf_ff;
         o_pending_ff     <= s1_pending_ff;
         o_ready_len_ff   <= s1_ready_len_ff;
         o_read_data_ff   <= s1_use_rd_ff ? mem_rdata_ff : 8'h00;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_ready    = o_frame_ready_ff;
   assign rsp_crc_bad        = o_crc_bad_ff;
   assign rsp_length_dropped = o_dropped_ff;
   assign rsp_ready_buffer   = o_ready_buf_ff;
   assign rsp_ready_pending  = o_pending_ff;
   assign rsp_ready_length   = o_ready_len_ff;
   assign rsp_read_data      = o_read_data_ff;

endmodule

@@ rtl/cfpr_checker.sv @@
module cfpr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_frame_ready,
   input logic       rsp_crc_bad,
   input logic       rsp_length_dropped,
   input logic       rsp_ready_buffer,
   input logic       rsp_ready_pending,
   input logic [7:0] rsp_ready_length,
   input logic [7:0] rsp_read_data
);

   // store is being zeroed right after reset
   a_stall_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("req_stall low right after reset");

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_frame_ready, rsp_crc_bad, rsp_length_dropped}))
      else $error("more than one event flag in a word");

   a_event_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_ready || rsp_crc_bad || rsp_length_dropped))
         |-> (rsp_read_data == 8'h00))
      else $error("read data nonzero on a receive word");

   a_good_frame_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_ready) |-> rsp_ready_pending)
      else $error("good frame not marked new");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ready_length)
         && $stable(rsp_read_data) && $stable(rsp_ready_buffer)))
      else $error("stalled response word changed");

endmodule

bind crc_framed_packet_receiver cfpr_checker u_cfpr_checker (.*);
